// ===== rtl/camera_matrix_decompose_defines.svh =====
// ----------------------------------------------------------------------------
// Camera matrix decomposition: assertion macros
// Shared property templates for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CAMERA_MATRIX_DECOMPOSE_DEFINES_SVH
`define CAMERA_MATRIX_DECOMPOSE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMDEC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CMDEC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cmdec_pkg.sv =====
// ----------------------------------------------------------------------------
// Camera matrix decomposition package
// Widths, operation codes, register file map, fixed-point helpers and the
// operation program executed by the controller.
// ----------------------------------------------------------------------------
package cmdec_pkg;

	localparam int VALUE_WIDTH = 48;
	localparam int FRAC_BITS   = 24;

	localparam int SQ_WIDTH   = 2 * VALUE_WIDTH + 2;
	localparam int ROOT_WIDTH = SQ_WIDTH / 2;
	localparam int SREM_WIDTH = ROOT_WIDTH + 3;
	localparam int NUM_WIDTH  = VALUE_WIDTH + FRAC_BITS + 1;
	localparam int RND_WIDTH  = 2 * VALUE_WIDTH + 1 - FRAC_BITS;
	localparam int SAT_A      = (NUM_WIDTH > RND_WIDTH) ? NUM_WIDTH : RND_WIDTH;
	localparam int SAT_WIDTH  = (SAT_A > ROOT_WIDTH) ? SAT_A : ROOT_WIDTH;
	localparam int CNT_WIDTH  = $clog2(SAT_WIDTH + 1);

	localparam int RF_DEPTH = 64;
	localparam int RF_AW    = $clog2(RF_DEPTH);

	localparam int PROG_LEN = 98;
	localparam int PC_WIDTH = $clog2(PROG_LEN);

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic [RF_AW-1:0] rf_addr_t;
	typedef logic [2:0] op_t;

	localparam logic [VALUE_WIDTH-1:0] MAXV = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [2*VALUE_WIDTH-1:0] HALF_LSB = (2*VALUE_WIDTH)'(1) << (FRAC_BITS - 1);

	localparam op_t OP_ADD  = 3'd0;
	localparam op_t OP_SUB  = 3'd1;
	localparam op_t OP_NEG  = 3'd2;
	localparam op_t OP_MUL  = 3'd3;
	localparam op_t OP_SQ0  = 3'd4;
	localparam op_t OP_SQA  = 3'd5;
	localparam op_t OP_DIV  = 3'd6;
	localparam op_t OP_SQRT = 3'd7;

	// Register file map. Addresses below A_GAM hold the loaded entries.
	localparam int NUM_ENTRIES = 12;
	localparam int A_GAM = 12;
	localparam int A_R   = 13;
	localparam int A_C4  = 22;
	localparam int A_Q13 = 25;
	localparam int A_Q23 = 28;
	localparam int A_FU  = 31;
	localparam int A_FV  = 32;
	localparam int A_DU  = 33;
	localparam int A_DV  = 34;
	localparam int A_ROT = 35;
	localparam int A_RT  = 41;
	localparam int A_POS = 44;
	localparam int A_T0  = 47;
	localparam int A_T1  = 48;
	localparam int A_T2  = 49;
	localparam int A_W   = 50;

	typedef struct packed {
		op_t      op;
		rf_addr_t a;
		rf_addr_t b;
		rf_addr_t d;
		logic     zchk;
	} instr_t;

	typedef struct packed {
		logic     ld_we;
		rf_addr_t ld_addr;
		logic     rd_en;
		rf_addr_t rd_a;
		rf_addr_t rd_b;
		logic     start;
		op_t      op;
		rf_addr_t dst;
		logic     out_load;
		logic     out_zero;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic zero;
	} sts_t;

	function automatic logic [VALUE_WIDTH-1:0] mag(input value_t x);
		return x[VALUE_WIDTH-1] ? VALUE_WIDTH'(-x) : VALUE_WIDTH'(x);
	endfunction

	function automatic value_t sat_mag(input logic neg, input logic [SAT_WIDTH-1:0] m);
		logic [SAT_WIDTH-1:0] lim;
		logic [VALUE_WIDTH-1:0] v;
		lim = SAT_WIDTH'(MAXV) + SAT_WIDTH'(neg);
		v = (m > lim) ? lim[VALUE_WIDTH-1:0] : m[VALUE_WIDTH-1:0];
		return neg ? value_t'(-v) : value_t'(v);
	endfunction

	function automatic value_t sat_add(input value_t a, input value_t b, input logic sub);
		logic signed [VALUE_WIDTH:0] s;
		s = sub ? ({a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b})
			: ({a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b});
		if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
			return s[VALUE_WIDTH] ? value_t'(~MAXV) : value_t'(MAXV);
		end
		return s[VALUE_WIDTH-1:0];
	endfunction

	// Physical address of a matrix entry given its row-major position.
	function automatic rf_addr_t entry_addr(input rf_addr_t a, input logic col_major);
		logic [1:0] row;
		logic [1:0] col;
		row = a[3:2];
		col = a[1:0];
		if (col_major && a < RF_AW'(NUM_ENTRIES)) begin
			return rf_addr_t'({col, 1'b0}) + rf_addr_t'(col) + rf_addr_t'(row);
		end
		return a;
	endfunction

	function automatic rf_addr_t result_addr(input logic [3:0] k);
		unique case (k)
			4'd0: return rf_addr_t'(A_FU);
			4'd1: return rf_addr_t'(A_FV);
			4'd2: return rf_addr_t'(A_DU);
			4'd3: return rf_addr_t'(A_DV);
			4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9: return rf_addr_t'(A_ROT - 4) + rf_addr_t'(k);
			4'd10, 4'd11, 4'd12: return rf_addr_t'(A_R - 4) + rf_addr_t'(k);
			default: return rf_addr_t'(A_POS - 13) + rf_addr_t'(k);
		endcase
	endfunction

	function automatic instr_t mk(input op_t op, input int a, input int b, input int d,
		input logic z);
		instr_t r;
		r.op = op;
		r.a = rf_addr_t'(a);
		r.b = rf_addr_t'(b);
		r.d = rf_addr_t'(d);
		r.zchk = z;
		return r;
	endfunction

	function automatic instr_t prog(input logic [PC_WIDTH-1:0] pc);
		unique case (pc)
			// gamma = length of row three
			0:  return mk(OP_SQ0, 8, 8, 0, 1'b0);
			1:  return mk(OP_SQA, 9, 9, 0, 1'b0);
			2:  return mk(OP_SQA, 10, 10, 0, 1'b0);
			3:  return mk(OP_SQRT, 0, 0, A_GAM, 1'b1);
			// normalized rows and fourth column
			4:  return mk(OP_DIV, 0, A_GAM, A_R + 0, 1'b0);
			5:  return mk(OP_DIV, 1, A_GAM, A_R + 1, 1'b0);
			6:  return mk(OP_DIV, 2, A_GAM, A_R + 2, 1'b0);
			7:  return mk(OP_DIV, 4, A_GAM, A_R + 3, 1'b0);
			8:  return mk(OP_DIV, 5, A_GAM, A_R + 4, 1'b0);
			9:  return mk(OP_DIV, 6, A_GAM, A_R + 5, 1'b0);
			10: return mk(OP_DIV, 8, A_GAM, A_R + 6, 1'b0);
			11: return mk(OP_DIV, 9, A_GAM, A_R + 7, 1'b0);
			12: return mk(OP_DIV, 10, A_GAM, A_R + 8, 1'b0);
			13: return mk(OP_DIV, 3, A_GAM, A_C4 + 0, 1'b0);
			14: return mk(OP_DIV, 7, A_GAM, A_C4 + 1, 1'b0);
			15: return mk(OP_DIV, 11, A_GAM, A_C4 + 2, 1'b0);
			// q13 = r0 x r2
			16: return mk(OP_MUL, A_R + 1, A_R + 8, A_T0, 1'b0);
			17: return mk(OP_MUL, A_R + 2, A_R + 7, A_T1, 1'b0);
			18: return mk(OP_SUB, A_T0, A_T1, A_Q13 + 0, 1'b0);
			19: return mk(OP_MUL, A_R + 2, A_R + 6, A_T0, 1'b0);
			20: return mk(OP_MUL, A_R + 0, A_R + 8, A_T1, 1'b0);
			21: return mk(OP_SUB, A_T0, A_T1, A_Q13 + 1, 1'b0);
			22: return mk(OP_MUL, A_R + 0, A_R + 7, A_T0, 1'b0);
			23: return mk(OP_MUL, A_R + 1, A_R + 6, A_T1, 1'b0);
			24: return mk(OP_SUB, A_T0, A_T1, A_Q13 + 2, 1'b0);
			// q23 = r1 x r2
			25: return mk(OP_MUL, A_R + 4, A_R + 8, A_T0, 1'b0);
			26: return mk(OP_MUL, A_R + 5, A_R + 7, A_T1, 1'b0);
			27: return mk(OP_SUB, A_T0, A_T1, A_Q23 + 0, 1'b0);
			28: return mk(OP_MUL, A_R + 5, A_R + 6, A_T0, 1'b0);
			29: return mk(OP_MUL, A_R + 3, A_R + 8, A_T1, 1'b0);
			30: return mk(OP_SUB, A_T0, A_T1, A_Q23 + 1, 1'b0);
			31: return mk(OP_MUL, A_R + 3, A_R + 7, A_T0, 1'b0);
			32: return mk(OP_MUL, A_R + 4, A_R + 6, A_T1, 1'b0);
			33: return mk(OP_SUB, A_T0, A_T1, A_Q23 + 2, 1'b0);
			// fu and fv
			34: return mk(OP_SQ0, A_Q13 + 0, A_Q13 + 0, 0, 1'b0);
			35: return mk(OP_SQA, A_Q13 + 1, A_Q13 + 1, 0, 1'b0);
			36: return mk(OP_SQA, A_Q13 + 2, A_Q13 + 2, 0, 1'b0);
			37: return mk(OP_SQRT, 0, 0, A_FU, 1'b1);
			38: return mk(OP_SQ0, A_Q23 + 0, A_Q23 + 0, 0, 1'b0);
			39: return mk(OP_SQA, A_Q23 + 1, A_Q23 + 1, 0, 1'b0);
			40: return mk(OP_SQA, A_Q23 + 2, A_Q23 + 2, 0, 1'b0);
			41: return mk(OP_SQRT, 0, 0, A_FV, 1'b1);
			// du and dv
			42: return mk(OP_MUL, A_R + 0, A_R + 6, A_T0, 1'b0);
			43: return mk(OP_MUL, A_R + 1, A_R + 7, A_T1, 1'b0);
			44: return mk(OP_ADD, A_T0, A_T1, A_T2, 1'b0);
			45: return mk(OP_MUL, A_R + 2, A_R + 8, A_T0, 1'b0);
			46: return mk(OP_ADD, A_T2, A_T0, A_DU, 1'b0);
			47: return mk(OP_MUL, A_R + 3, A_R + 6, A_T0, 1'b0);
			48: return mk(OP_MUL, A_R + 4, A_R + 7, A_T1, 1'b0);
			49: return mk(OP_ADD, A_T0, A_T1, A_T2, 1'b0);
			50: return mk(OP_MUL, A_R + 5, A_R + 8, A_T0, 1'b0);
			51: return mk(OP_ADD, A_T2, A_T0, A_DV, 1'b0);
			// w = r2 x q13, rotation row one
			52: return mk(OP_MUL, A_R + 7, A_Q13 + 2, A_T0, 1'b0);
			53: return mk(OP_MUL, A_R + 8, A_Q13 + 1, A_T1, 1'b0);
			54: return mk(OP_SUB, A_T0, A_T1, A_W + 0, 1'b0);
			55: return mk(OP_MUL, A_R + 8, A_Q13 + 0, A_T0, 1'b0);
			56: return mk(OP_MUL, A_R + 6, A_Q13 + 2, A_T1, 1'b0);
			57: return mk(OP_SUB, A_T0, A_T1, A_W + 1, 1'b0);
			58: return mk(OP_MUL, A_R + 6, A_Q13 + 1, A_T0, 1'b0);
			59: return mk(OP_MUL, A_R + 7, A_Q13 + 0, A_T1, 1'b0);
			60: return mk(OP_SUB, A_T0, A_T1, A_W + 2, 1'b0);
			61: return mk(OP_DIV, A_W + 0, A_FU, A_ROT + 0, 1'b0);
			62: return mk(OP_DIV, A_W + 1, A_FU, A_ROT + 1, 1'b0);
			63: return mk(OP_DIV, A_W + 2, A_FU, A_ROT + 2, 1'b0);
			// w = r2 x q23, rotation row two
			64: return mk(OP_MUL, A_R + 7, A_Q23 + 2, A_T0, 1'b0);
			65: return mk(OP_MUL, A_R + 8, A_Q23 + 1, A_T1, 1'b0);
			66: return mk(OP_SUB, A_T0, A_T1, A_W + 0, 1'b0);
			67: return mk(OP_MUL, A_R + 8, A_Q23 + 0, A_T0, 1'b0);
			68: return mk(OP_MUL, A_R + 6, A_Q23 + 2, A_T1, 1'b0);
			69: return mk(OP_SUB, A_T0, A_T1, A_W + 1, 1'b0);
			70: return mk(OP_MUL, A_R + 6, A_Q23 + 1, A_T0, 1'b0);
			71: return mk(OP_MUL, A_R + 7, A_Q23 + 0, A_T1, 1'b0);
			72: return mk(OP_SUB, A_T0, A_T1, A_W + 2, 1'b0);
			73: return mk(OP_DIV, A_W + 0, A_FV, A_ROT + 3, 1'b0);
			74: return mk(OP_DIV, A_W + 1, A_FV, A_ROT + 4, 1'b0);
			75: return mk(OP_DIV, A_W + 2, A_FV, A_ROT + 5, 1'b0);
			// scaled fourth column
			76: return mk(OP_MUL, A_C4 + 2, A_DU, A_T0, 1'b0);
			77: return mk(OP_SUB, A_T0, A_C4 + 0, A_T1, 1'b0);
			78: return mk(OP_DIV, A_T1, A_FU, A_RT + 0, 1'b0);
			79: return mk(OP_MUL, A_C4 + 2, A_DV, A_T0, 1'b0);
			80: return mk(OP_SUB, A_T0, A_C4 + 1, A_T1, 1'b0);
			81: return mk(OP_DIV, A_T1, A_FV, A_RT + 1, 1'b0);
			82: return mk(OP_NEG, A_C4 + 2, A_C4 + 2, A_RT + 2, 1'b0);
			// position
			83: return mk(OP_MUL, A_ROT + 0, A_RT + 0, A_T0, 1'b0);
			84: return mk(OP_MUL, A_ROT + 1, A_RT + 1, A_T1, 1'b0);
			85: return mk(OP_ADD, A_T0, A_T1, A_T2, 1'b0);
			86: return mk(OP_MUL, A_ROT + 2, A_RT + 2, A_T0, 1'b0);
			87: return mk(OP_ADD, A_T2, A_T0, A_POS + 0, 1'b0);
			88: return mk(OP_MUL, A_ROT + 3, A_RT + 0, A_T0, 1'b0);
			89: return mk(OP_MUL, A_ROT + 4, A_RT + 1, A_T1, 1'b0);
			90: return mk(OP_ADD, A_T0, A_T1, A_T2, 1'b0);
			91: return mk(OP_MUL, A_ROT + 5, A_RT + 2, A_T0, 1'b0);
			92: return mk(OP_ADD, A_T2, A_T0, A_POS + 1, 1'b0);
			93: return mk(OP_MUL, A_R + 6, A_RT + 0, A_T0, 1'b0);
			94: return mk(OP_MUL, A_R + 7, A_RT + 1, A_T1, 1'b0);
			95: return mk(OP_ADD, A_T0, A_T1, A_T2, 1'b0);
			96: return mk(OP_MUL, A_R + 8, A_RT + 2, A_T0, 1'b0);
			97: return mk(OP_ADD, A_T2, A_T0, A_POS + 2, 1'b0);
			default: return mk(OP_ADD, A_T0, A_T0, A_T0, 1'b0);
		endcase
	endfunction

endpackage

// ===== rtl/cmdec_in_if.sv =====
// ----------------------------------------------------------------------------
// Matrix entry channel
// Valid/ready channel carrying one projection matrix entry per item.
// ----------------------------------------------------------------------------
interface cmdec_in_if;
	logic                                       valid;
	logic                                       ready;
	logic signed [cmdec_pkg::VALUE_WIDTH-1:0]   matrix_entry;

	modport source (output valid, output matrix_entry, input ready);
	modport sink (input valid, input matrix_entry, output ready);
endinterface

// ===== rtl/cmdec_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one decomposition result per item.
// ----------------------------------------------------------------------------
interface cmdec_out_if;
	logic                                       valid;
	logic                                       ready;
	logic signed [cmdec_pkg::VALUE_WIDTH-1:0]   value;
	logic [3:0]                                 value_index;
	logic                                       last;
	logic                                       degenerate;

	modport source (output valid, output value, output value_index, output last,
		output degenerate, input ready);
	modport sink (input valid, input value, input value_index, input last,
		input degenerate, output ready);
endinterface

// ===== rtl/cmdec_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel writing the input ordering register.
// ----------------------------------------------------------------------------
interface cmdec_cfg_if;
	logic valid;
	logic ready;
	logic column_major_input;

	modport source (output valid, output column_major_input, input ready);
	modport sink (input valid, input column_major_input, output ready);
endinterface

// ===== rtl/cmdec_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cmdec_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/cmdec_dp.sv =====
// ----------------------------------------------------------------------------
// Decomposition datapath
// Register file, sequential multiplier, restoring divider, digit-by-digit
// square root, saturating adder and the output value register.
// ----------------------------------------------------------------------------
module cmdec_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  cmdec_pkg::value_t entry,
	input  cmdec_pkg::cmd_t   cmd,
	output cmdec_pkg::sts_t   sts,
	output cmdec_pkg::value_t out_value
);
	import cmdec_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_WIDTH-1:0]   cnt_q;
	op_t                    op_q;
	rf_addr_t               dst_q;
	logic                   neg_q;
	logic                   wr_q;
	value_t                 res_q;
	value_t                 out_q;
	logic [2*VALUE_WIDTH-1:0] mcand_q;
	logic [2*VALUE_WIDTH-1:0] prod_q;
	logic [VALUE_WIDTH-1:0] mplier_q;
	logic [VALUE_WIDTH-1:0] div_q;
	logic [NUM_WIDTH-1:0]   num_q;
	logic [NUM_WIDTH-1:0]   quo_q;
	logic [VALUE_WIDTH:0]   rem_q;
	logic [SQ_WIDTH-1:0]    sqacc_q;
	logic [SREM_WIDTH-1:0]  srem_q;
	logic [ROOT_WIDTH-1:0]  root_q;

	value_t                 rda;
	value_t                 rdb;
	logic                   rf_we;
	rf_addr_t               rf_waddr;
	value_t                 rf_wdata;
	logic [VALUE_WIDTH-1:0] mag_a;
	logic [VALUE_WIDTH-1:0] mag_b;
	logic                   running;
	logic                   finish;
	logic [VALUE_WIDTH:0]   r2;
	logic                   dge;
	logic [SREM_WIDTH-1:0]  srn;
	logic [SREM_WIDTH-1:0]  trial;
	logic                   sge;
	logic [2*VALUE_WIDTH-1:0] rnd;
	value_t                 fin_res;
	value_t                 alu_res;

	assign rf_we    = cmd.ld_we | (done_q & wr_q);
	assign rf_waddr = cmd.ld_we ? cmd.ld_addr : dst_q;
	assign rf_wdata = cmd.ld_we ? entry : res_q;

	cmdec_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(RF_DEPTH)) u_rf_a (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(cmd.rd_en), .raddr(cmd.rd_a), .rdata(rda)
	);

	cmdec_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(RF_DEPTH)) u_rf_b (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(cmd.rd_en), .raddr(cmd.rd_b), .rdata(rdb)
	);

	always_comb begin
		mag_a   = mag(rda);
		mag_b   = mag(rdb);
		running = busy_q && (cnt_q != '0);
		finish  = busy_q && (cnt_q == '0);
		r2      = {rem_q[VALUE_WIDTH-1:0], num_q[NUM_WIDTH-1]};
		dge     = r2 >= {1'b0, div_q};
		srn     = {srem_q[SREM_WIDTH-3:0], sqacc_q[SQ_WIDTH-1 -: 2]};
		trial   = SREM_WIDTH'({root_q, 2'b01});
		sge     = srn >= trial;
		rnd     = prod_q + HALF_LSB;
		case (op_q)
			OP_MUL:  fin_res = sat_mag(neg_q, SAT_WIDTH'(rnd >> FRAC_BITS));
			OP_DIV:  fin_res = (div_q == '0) ? '0 : sat_mag(neg_q, SAT_WIDTH'(quo_q));
			OP_SQRT: fin_res = sat_mag(1'b0, SAT_WIDTH'(root_q));
			default: fin_res = '0;
		endcase
		case (cmd.op)
			OP_ADD:  alu_res = sat_add(rda, rdb, 1'b0);
			OP_SUB:  alu_res = sat_add(rda, rdb, 1'b1);
			OP_NEG:  alu_res = sat_add('0, rda, 1'b1);
			default: alu_res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (cmd.start) begin
				case (cmd.op) inside
					OP_ADD, OP_SUB, OP_NEG: begin
						done_q <= 1'b1;
					end
					OP_DIV: begin
						done_q <= 1'b0;
						busy_q <= 1'b1;
						cnt_q  <= CNT_WIDTH'(NUM_WIDTH);
					end
					OP_SQRT: begin
						done_q <= 1'b0;
						busy_q <= 1'b1;
						cnt_q  <= CNT_WIDTH'(ROOT_WIDTH);
					end
					default: begin
						done_q <= 1'b0;
						busy_q <= 1'b1;
						cnt_q  <= CNT_WIDTH'(VALUE_WIDTH);
					end
				endcase
			end else if (finish) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
				if (running) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q     <= cmd.op;
			dst_q    <= cmd.dst;
			neg_q    <= rda[VALUE_WIDTH-1] ^ rdb[VALUE_WIDTH-1];
			wr_q     <= (cmd.op != OP_SQ0) && (cmd.op != OP_SQA);
			res_q    <= alu_res;
			mcand_q  <= (2*VALUE_WIDTH)'(mag_a);
			mplier_q <= mag_b;
			prod_q   <= '0;
			num_q    <= NUM_WIDTH'({mag_a, {FRAC_BITS{1'b0}}}) + NUM_WIDTH'(mag_b >> 1);
			div_q    <= mag_b;
			rem_q    <= '0;
			quo_q    <= '0;
			srem_q   <= '0;
			root_q   <= '0;
		end else if (running) begin
			case (op_q)
				OP_DIV: begin
					rem_q <= dge ? (r2 - {1'b0, div_q}) : r2;
					quo_q <= {quo_q[NUM_WIDTH-2:0], dge};
					num_q <= num_q << 1;
				end
				OP_SQRT: begin
					srem_q  <= sge ? (srn - trial) : srn;
					root_q  <= {root_q[ROOT_WIDTH-2:0], sge};
					sqacc_q <= sqacc_q << 2;
				end
				default: begin
					if (mplier_q[0]) begin
						prod_q <= prod_q + mcand_q;
					end
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end
			endcase
		end else if (finish) begin
			res_q <= fin_res;
			if (op_q == OP_SQ0) begin
				sqacc_q <= SQ_WIDTH'(prod_q);
			end else if (op_q == OP_SQA) begin
				sqacc_q <= sqacc_q + SQ_WIDTH'(prod_q);
			end
		end
		if (cmd.out_load) begin
			out_q <= cmd.out_zero ? '0 : rda;
		end
	end

	assign sts.done  = done_q;
	assign sts.zero  = (res_q == '0);
	assign out_value = out_q;
endmodule

// ===== rtl/cmdec_ctrl.sv =====
// ----------------------------------------------------------------------------
// Decomposition controller
// Loads the twelve entries, steps the operation program through the
// datapath and then reads the sixteen results out one by one.
// ----------------------------------------------------------------------------
module cmdec_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            cfg_valid,
	input  logic            cfg_col_major,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [3:0]      out_index,
	output logic            out_last,
	output logic            out_degen,
	output cmdec_pkg::cmd_t cmd,
	input  cmdec_pkg::sts_t sts
);
	import cmdec_pkg::*;

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_FETCH = 3'd1;
	localparam logic [2:0] S_EXEC  = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_ORD   = 3'd4;
	localparam logic [2:0] S_OLD   = 3'd5;
	localparam logic [2:0] S_OHOLD = 3'd6;

	logic [2:0]          state_q;
	logic [3:0]          cnt_q;
	logic [PC_WIDTH-1:0] pc_q;
	logic [3:0]          k_q;
	logic                degen_q;
	logic                colmaj_q;
	instr_t              ins;

	assign ins = prog(pc_q);

	always_comb begin
		cmd         = '0;
		cmd.ld_addr = rf_addr_t'(cnt_q);
		cmd.op      = ins.op;
		cmd.dst     = ins.d;
		cmd.out_zero = degen_q;
		unique case (state_q)
			S_LOAD: begin
				cmd.ld_we = in_valid;
			end
			S_FETCH: begin
				cmd.rd_en = 1'b1;
				cmd.rd_a  = entry_addr(ins.a, colmaj_q);
				cmd.rd_b  = entry_addr(ins.b, colmaj_q);
			end
			S_EXEC: begin
				cmd.start = 1'b1;
			end
			S_ORD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_a  = result_addr(k_q);
			end
			S_OLD: begin
				cmd.out_load = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			cnt_q    <= '0;
			pc_q     <= '0;
			k_q      <= '0;
			degen_q  <= 1'b0;
			colmaj_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				colmaj_q <= cfg_col_major;
			end
			unique case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (cnt_q == 4'(NUM_ENTRIES - 1)) begin
							cnt_q   <= '0;
							pc_q    <= '0;
							degen_q <= 1'b0;
							state_q <= S_FETCH;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_FETCH: state_q <= S_EXEC;
				S_EXEC:  state_q <= S_WAIT;
				S_WAIT: begin
					if (sts.done) begin
						if (ins.zchk && sts.zero) begin
							degen_q <= 1'b1;
						end
						if (pc_q == PC_WIDTH'(PROG_LEN - 1)) begin
							k_q     <= '0;
							state_q <= S_ORD;
						end else begin
							pc_q    <= pc_q + 1'b1;
							state_q <= S_FETCH;
						end
					end
				end
				S_ORD: state_q <= S_OLD;
				S_OLD: state_q <= S_OHOLD;
				S_OHOLD: begin
					if (out_ready) begin
						if (k_q == 4'd15) begin
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_ORD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_OHOLD);
	assign out_index = k_q;
	assign out_last  = (k_q == 4'd15);
	assign out_degen = degen_q;
endmodule

// ===== rtl/camera_matrix_decompose.sv =====
// ----------------------------------------------------------------------------
// Camera matrix decomposition
// Splits a 3x4 projection matrix into fu, fv, du, dv, rotation and position.
// ----------------------------------------------------------------------------
// Entries are taken one per cycle while loading; the twelfth starts a run of
// 98 fixed-point operations on one shared datapath. Each operation is fetched
// from the register file and issued; an add needs no sequential unit, while a
// multiply or square, a divide or a square root then waits for its unit. The
// sixteen results are then each read from the register file and loaded into
// the output register before they are offered, the next only after the one
// before is taken, and no entry is taken until the last of them has gone. A
// zero gamma, fu or fv gives sixteen zero values with the degenerate flag set.
`include "camera_matrix_decompose_defines.svh"

module camera_matrix_decompose (
	input logic        clk,
	input logic        arst_n,
	cmdec_in_if.sink   entry,
	cmdec_out_if.source result,
	cmdec_cfg_if.sink  cfg
);
	import cmdec_pkg::*;

	cmd_t   cmd;
	sts_t   sts;
	value_t out_value;

	assign cfg.ready = 1'b1;

	cmdec_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(entry.valid),
		.in_ready(entry.ready),
		.cfg_valid(cfg.valid),
		.cfg_col_major(cfg.column_major_input),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.out_index(result.value_index),
		.out_last(result.last),
		.out_degen(result.degenerate),
		.cmd(cmd),
		.sts(sts)
	);

	cmdec_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.entry(entry.matrix_entry),
		.cmd(cmd),
		.sts(sts),
		.out_value(out_value)
	);

	assign result.value = out_value;

	`CMDEC_ASSERT_NOW(a_no_load_during_output, result.valid, !entry.ready, "entry taken while results pending")
	`CMDEC_ASSERT_NOW(a_degenerate_is_zero, result.valid && result.degenerate, result.value == '0, "degenerate run with nonzero value")
	`CMDEC_ASSERT_NEXT(a_read_gap_after_take, result.valid && result.ready && !result.last, !result.valid, "result valid without register file read")
endmodule

// ===== tb/tb_camera_matrix_decompose.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera matrix decomposition testbench
// Loads projection matrices in both entry orders and checks every result item
// field by field against a fixed-point decomposition computed alongside.
// ----------------------------------------------------------------------------
module tb_camera_matrix_decompose;
	import cmdec_pkg::*;

	typedef struct {
		value_t     value;
		logic [3:0] index;
		logic       last;
		logic       degenerate;
	} result_item_t;

	typedef struct {
		value_t entries[12];
		bit     zero_typed;
	} matrix_row_t;

	localparam value_t VMAX = value_t'(MAXV);
	localparam value_t VMIN = value_t'(~MAXV);
	localparam value_t ONE  = value_t'(1) <<< FRAC_BITS;

	logic clk;
	logic arst_n;

	cmdec_in_if  entry ();
	cmdec_out_if result ();
	cmdec_cfg_if cfg ();

	camera_matrix_decompose u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.entry  (entry.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	result_item_t expected_results[$];
	value_t       loaded_entries[12];
	int           loaded_count;
	logic         col_major;
	int           mismatches;
	int           runs_received;
	bit           quiet;
	bit           failed;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		#(20 * 600000);
		$display("TEST FAILED");
		$finish;
	end

	// Fixed-point arithmetic on magnitudes held in 128 bits.
	function automatic logic [127:0] magnitude(value_t x);
		logic signed [48:0] t;
		t = x;
		if (t < 0) t = -t;
		return {79'd0, t};
	endfunction

	function automatic value_t clamp_mag(bit neg, logic [127:0] m);
		logic [127:0] lim;
		lim = {80'd0, MAXV} + (neg ? 128'd1 : 128'd0);
		if (m > lim) m = lim;
		return neg ? value_t'(-m[VALUE_WIDTH-1:0]) : value_t'(m[VALUE_WIDTH-1:0]);
	endfunction

	function automatic value_t q_add(value_t a, value_t b);
		logic signed [48:0] s;
		s = {a[47], a} + {b[47], b};
		if (s[48] != s[47]) return s[48] ? VMIN : VMAX;
		return s[47:0];
	endfunction

	function automatic value_t q_sub(value_t a, value_t b);
		logic signed [48:0] s;
		s = {a[47], a} - {b[47], b};
		if (s[48] != s[47]) return s[48] ? VMIN : VMAX;
		return s[47:0];
	endfunction

	function automatic value_t q_mul(value_t a, value_t b);
		logic [127:0] m;
		m = magnitude(a) * magnitude(b) + (128'd1 << (FRAC_BITS - 1));
		return clamp_mag((a < 0) != (b < 0), m >> FRAC_BITS);
	endfunction

	function automatic value_t q_div(value_t a, value_t b);
		logic [127:0] d;
		logic [127:0] n;
		if (b == 0) return '0;
		d = magnitude(b);
		n = (magnitude(a) << FRAC_BITS) + (d >> 1);
		return clamp_mag((a < 0) != (b < 0), n / d);
	endfunction

	function automatic value_t q_length(value_t x, value_t y, value_t z);
		logic [127:0] s;
		logic [127:0] c;
		logic [63:0]  root;
		s = magnitude(x) * magnitude(x) + magnitude(y) * magnitude(y)
			+ magnitude(z) * magnitude(z);
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			c = {64'd0, root | (64'd1 << b)};
			if (c * c <= s) root = c[63:0];
		end
		return clamp_mag(1'b0, {64'd0, root});
	endfunction

	function automatic value_t q_dot(value_t a[3], value_t b[3]);
		return q_add(q_add(q_mul(a[0], b[0]), q_mul(a[1], b[1])), q_mul(a[2], b[2]));
	endfunction

	function automatic void q_cross(value_t a[3], value_t b[3], output value_t o[3]);
		o[0] = q_sub(q_mul(a[1], b[2]), q_mul(a[2], b[1]));
		o[1] = q_sub(q_mul(a[2], b[0]), q_mul(a[0], b[2]));
		o[2] = q_sub(q_mul(a[0], b[1]), q_mul(a[1], b[0]));
	endfunction

	function automatic void decompose_matrix(value_t e[12], logic cm, output value_t res[16],
		output bit deg);
		value_t p[3][4];
		value_t r[3][3];
		value_t c4[3];
		value_t q13[3];
		value_t q23[3];
		value_t w[3];
		value_t rot[3][3];
		value_t rt[3];
		value_t gamma;
		value_t fu;
		value_t fv;
		value_t du;
		value_t dv;
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 4; k++)
				p[i][k] = e[cm ? 3 * k + i : 4 * i + k];
		for (int i = 0; i < 16; i++) res[i] = '0;
		deg = 1'b1;
		gamma = q_length(p[2][0], p[2][1], p[2][2]);
		if (gamma == 0) return;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) r[i][k] = q_div(p[i][k], gamma);
			c4[i] = q_div(p[i][3], gamma);
		end
		q_cross(r[0], r[2], q13);
		q_cross(r[1], r[2], q23);
		fu = q_length(q13[0], q13[1], q13[2]);
		fv = q_length(q23[0], q23[1], q23[2]);
		du = q_dot(r[0], r[2]);
		dv = q_dot(r[1], r[2]);
		if (fu == 0 || fv == 0) return;
		q_cross(r[2], q13, w);
		for (int k = 0; k < 3; k++) rot[0][k] = q_div(w[k], fu);
		q_cross(r[2], q23, w);
		for (int k = 0; k < 3; k++) rot[1][k] = q_div(w[k], fv);
		rot[2] = r[2];
		rt[0] = q_div(q_sub(q_mul(c4[2], du), c4[0]), fu);
		rt[1] = q_div(q_sub(q_mul(c4[2], dv), c4[1]), fv);
		rt[2] = q_sub('0, c4[2]);
		deg = 1'b0;
		res[0] = fu;
		res[1] = fv;
		res[2] = du;
		res[3] = dv;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) res[4 + 3 * i + k] = rot[i][k];
			res[13 + i] = q_dot(rot[i], rt);
		end
	endfunction

	// Called for every accepted entry; the twelfth of a matrix queues its results.
	task automatic record_entry(value_t v, bit zero_typed);
		value_t res[16];
		bit deg;
		loaded_entries[loaded_count] = v;
		loaded_count++;
		if (loaded_count < 12) return;
		loaded_count = 0;
		if (zero_typed) begin
			res = '{default: '0};
			deg = 1'b1;
		end else begin
			decompose_matrix(loaded_entries, col_major, res, deg);
		end
		for (int k = 0; k < 16; k++)
			expected_results.push_back('{res[k], 4'(k), k == 15, deg});
	endtask

	task automatic send_entry(value_t v, bit zero_typed);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			entry.valid = 1'b0;
			repeat ($urandom_range(1, 6) - 1) @(negedge clk);
		end
		@(negedge clk);
		entry.valid = 1'b1;
		entry.matrix_entry = v;
		do @(posedge clk); while (!entry.ready);
		record_entry(v, zero_typed);
	endtask

	task automatic send_matrix(value_t m[12], bit zero_typed);
		for (int k = 0; k < 12; k++)
			send_entry(col_major ? m[4 * (k % 3) + k / 3] : m[k], zero_typed);
	endtask

	task automatic write_order(logic v);
		@(negedge clk);
		entry.valid = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
		cfg.valid = 1'b1;
		cfg.column_major_input = v;
		do @(posedge clk); while (!cfg.ready);
		col_major = v;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	function automatic value_t any_value();
		return value_t'({$urandom, $urandom});
	endfunction

	function automatic value_t extreme_value();
		case ($urandom_range(0, 4))
			0: return VMAX;
			1: return VMIN;
			2: return '0;
			3: return value_t'(1);
			default: return value_t'(-1);
		endcase
	endfunction

	function automatic value_t camera_value();
		return value_t'($signed(32'($urandom))) <<< $urandom_range(0, 10);
	endfunction

	task automatic make_matrix(output value_t m[12]);
		int mode;
		mode = $urandom_range(0, 19);
		for (int k = 0; k < 12; k++) begin
			if (mode < 3) m[k] = any_value();
			else if (mode < 6) m[k] = extreme_value();
			else m[k] = camera_value();
		end
		if (mode == 16 || mode == 17) for (int k = 0; k < 4; k++) m[k] = m[8 + k];
		if (mode == 18) for (int k = 4; k < 8; k++) m[k] = m[8 + k - 4];
		if (mode == 19) for (int k = 8; k < 11; k++) m[k] = '0;
	endtask

	matrix_row_t directed[2];

	initial begin
		value_t m[12];
		entry.valid = 1'b0;
		entry.matrix_entry = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.column_major_input = 1'b0;
		loaded_count = 0;
		col_major = 1'b0;
		mismatches = 0;
		runs_received = 0;
		quiet = 1'b0;
		failed = 1'b0;
		directed[0].entries = '{default: '0};
		directed[0].zero_typed = 1'b1;
		directed[1].entries = '{VMAX, VMIN, VMAX, VMIN, VMIN, VMAX, value_t'(1), VMAX,
			ONE, VMIN, VMAX, VMIN};
		directed[1].zero_typed = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) send_matrix(directed[i].entries, directed[i].zero_typed);

		for (int phase = 0; phase < 4; phase++) begin
			write_order(phase % 2 == 0);
			if (phase == 3) quiet = 1'b1;
			for (int n = 0; n < 4; n++) begin
				make_matrix(m);
				send_matrix(m, 1'b0);
			end
		end
		@(negedge clk);
		entry.valid = 1'b0;

		while (expected_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (!failed && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Receiver side: random stalls outside the quiet phase, and one long hold-off during a result burst.
	initial begin
		int stall;
		int hold;
		bit held;
		stall = 0;
		hold = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && runs_received == 3 && result.valid) begin
				hold = 300;
				held = 1'b1;
			end
			if (hold > 0) begin
				result.ready = 1'b0;
				hold--;
			end else if (quiet) begin
				result.ready = 1'b1;
			end else if (stall > 0) begin
				result.ready = 1'b0;
				stall--;
			end else if ($urandom_range(0, 7) == 0) begin
				result.ready = 1'b0;
				stall = $urandom_range(1, 6) - 1;
			end else begin
				result.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		result_item_t want;
		if (arst_n && result.valid && result.ready) begin
			if (expected_results.size() == 0) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result item: index %0d value %0d",
						result.value_index, result.value);
			end else begin
				want = expected_results.pop_front();
				if (result.value !== want.value || result.value_index !== want.index
					|| result.last !== want.last || result.degenerate !== want.degenerate) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected idx %0d val %0d last %0b deg %0b, got idx %0d val %0d last %0b deg %0b",
							want.index, want.value, want.last, want.degenerate,
							result.value_index, result.value, result.last, result.degenerate);
				end
				if (want.last) runs_received++;
			end
		end
	end

endmodule
